>>> rtl/apf_pkg.sv
// Package with the shared types and constants of the packet header filter.
`default_nettype none

package apf_pkg;

    // Default ceiling of the saturating payload counter.
    localparam int unsigned MAX_PACKET_BYTES_DEF = 255;

    // Address that every node accepts.
    localparam logic [7:0] BROADCAST_ADDR = 8'hFF;

    // Value of a header field that has not been received yet.
    localparam logic [7:0] EMPTY_FIELD = 8'hFF;

    // Number of header bytes in front of the payload.
    localparam logic [2:0] HEADER_BYTES = 3'd4;

    // Header byte positions.
    localparam logic [2:0] HDR_DEST   = 3'd0;
    localparam logic [2:0] HDR_SOURCE = 3'd1;
    localparam logic [2:0] HDR_MSG_ID = 3'd2;
    localparam logic [2:0] HDR_LENGTH = 3'd3;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_FOR_ME  = 2'd1,
        ST_BAD_LENGTH  = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] payload_data;
        logic       payload_valid;
        logic       packet_done;
        logic [1:0] status;
        logic [7:0] destination;
        logic [7:0] source;
        logic [7:0] message_id;
        logic [7:0] declared_length;
        logic [7:0] payload_count;
    } t_out_word;

endpackage

`default_nettype wire

>>> rtl/apf_parse.sv
// Header capture, payload counting and status decision for one accepted byte per cycle.
`default_nettype none

module apf_parse #(
    parameter int unsigned MAX_PACKET_BYTES = apf_pkg::MAX_PACKET_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire apf_pkg::t_in_word i_word,
    input  wire logic [7:0]        i_local_address,
    output apf_pkg::t_out_word     o_result
);
    import apf_pkg::*;

    localparam logic [7:0] MaxCount = 8'(MAX_PACKET_BYTES);

    logic [2:0] r_position;
    logic [7:0] r_dest;
    logic [7:0] r_source;
    logic [7:0] r_msg_id;
    logic [7:0] r_length;
    logic [7:0] r_count;

    logic [2:0] n_position;
    logic [7:0] n_dest;
    logic [7:0] n_source;
    logic [7:0] n_msg_id;
    logic [7:0] n_length;
    logic [7:0] n_count;
    logic       is_payload;
    t_status    status;

    // Update of the packet state as if this byte were accepted.
    always_comb begin
        n_position = r_position;
        n_dest     = r_dest;
        n_source   = r_source;
        n_msg_id   = r_msg_id;
        n_length   = r_length;
        n_count    = r_count;
        is_payload = (r_position >= HEADER_BYTES);
        if (is_payload) begin
            if (r_count < MaxCount) begin
                n_count = r_count + 8'd1;
            end
        end else begin
            case (r_position)
                HDR_DEST:   n_dest   = i_word.rx_byte;
                HDR_SOURCE: n_source = i_word.rx_byte;
                HDR_MSG_ID: n_msg_id = i_word.rx_byte;
                default:    n_length = i_word.rx_byte;
            endcase
            n_position = r_position + 3'd1;
        end
    end

    // The destination check takes precedence over the length check.
    always_comb begin
        if (n_dest != i_local_address && n_dest != BROADCAST_ADDR) begin
            status = ST_NOT_FOR_ME;
        end else if (n_position < HEADER_BYTES || n_count != n_length) begin
            status = ST_BAD_LENGTH;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        o_result = '0;
        if (is_payload) begin
            o_result.payload_data  = i_word.rx_byte;
            o_result.payload_valid = 1'b1;
        end
        if (i_word.last_byte) begin
            o_result.packet_done     = 1'b1;
            o_result.status          = status;
            o_result.destination     = n_dest;
            o_result.source          = n_source;
            o_result.message_id      = n_msg_id;
            o_result.declared_length = n_length;
            o_result.payload_count   = n_count;
        end
    end

    // The final byte returns all packet state to its start values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_dest     <= EMPTY_FIELD;
            r_source   <= EMPTY_FIELD;
            r_msg_id   <= EMPTY_FIELD;
            r_length   <= EMPTY_FIELD;
            r_count    <= '0;
        end else if (i_accept) begin
            if (i_word.last_byte) begin
                r_position <= '0;
                r_dest     <= EMPTY_FIELD;
                r_source   <= EMPTY_FIELD;
                r_msg_id   <= EMPTY_FIELD;
                r_length   <= EMPTY_FIELD;
                r_count    <= '0;
            end else begin
                r_position <= n_position;
                r_dest     <= n_dest;
                r_source   <= n_source;
                r_msg_id   <= n_msg_id;
                r_length   <= n_length;
                r_count    <= n_count;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/apf_out_reg.sv
// Result register between the decision logic and the output channel.
`default_nettype none

module apf_out_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire apf_pkg::t_out_word i_result,
    output logic                    o_full_blocked,
    input  wire logic               i_out_stall,
    output logic                    o_out_valid,
    output apf_pkg::t_out_word      o_out_word
);
    import apf_pkg::*;

    logic      r_valid;
    t_out_word r_word;

    // A new word may enter when the register is empty or is being taken.
    assign o_full_blocked = r_valid && i_out_stall;
    assign o_out_valid    = r_valid;
    assign o_out_word     = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_result;
        end
    end

endmodule

`default_nettype wire

>>> rtl/addressed_packet_header_filter.sv
// Top level of the addressed packet header filter.
// The block takes a received packet one byte per input word, header first:
// destination, source, message id and declared payload length, then payload.
// The input channel carries rx_byte and last_byte; a word is taken at a rising
// edge with i_in_valid high and o_in_stall low. Every input word yields exactly
// one output word. Payload bytes come out with payload_valid set, and the
// output word for the final byte carries packet_done, the header fields, the
// saturating payload count and the status (ok, not for this node, or length
// mismatch; not for this node takes precedence over length mismatch).
// Results are registered: the result of a word taken at one edge is offered
// on o_out_valid after that edge. Throughput is one word per cycle while the
// receiver does not stall; the result register refills in the cycle it drains.
// When the receiver stalls, the result register holds its word and o_in_stall
// rises, so no more input is taken until the word is delivered.
// The local address is written through its own valid/ready port, which is
// always ready. A synchronous active-low reset empties the result register,
// clears the header state to its start values and sets the local address to 0.
`default_nettype none

module addressed_packet_header_filter #(
    parameter int unsigned MAX_PACKET_BYTES = apf_pkg::MAX_PACKET_BYTES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [7:0]         i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire apf_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output apf_pkg::t_out_word      o_out_word
);
    import apf_pkg::*;

    logic [7:0] r_local_address;
    logic       in_accept;
    logic       out_blocked;
    t_out_word  result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_address <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_local_address <= i_cfg_data;
        end
    end

    // Input is held off only while a finished word waits on a stalled receiver.
    assign o_in_stall = out_blocked;
    assign in_accept  = i_in_valid && !out_blocked;

    apf_parse #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_parse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_word          (i_in_word),
        .i_local_address (r_local_address),
        .o_result        (result)
    );

    apf_out_reg u_out_reg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (in_accept),
        .i_result       (result),
        .o_full_blocked (out_blocked),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_out_word     (o_out_word)
    );

    // Words that do not close a packet carry no header or status information.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.packet_done |->
            o_out_word.status == ST_OK && o_out_word.destination == 8'd0 &&
            o_out_word.payload_count == 8'd0)
        else $error("header fields set on a word that does not end a packet");

    // The payload counter never passes its ceiling.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.payload_count <= 8'(MAX_PACKET_BYTES))
        else $error("payload count above the configured maximum");

    // An accepted packet is only reported ok when the count matches the header.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.packet_done && o_out_word.status == ST_OK |->
            o_out_word.payload_count == o_out_word.declared_length)
        else $error("ok status with a payload length mismatch");

    // Reset empties the result register.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire
